// ----- rtl/core/bre_pkg.sv -----
// Package with the shared types, codes and defaults of the bitmap range engine.
`timescale 1ns / 1ps

package bre_pkg;

  localparam int unsigned MAX_BITS_DEF  = 1024;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned POS_W         = 10;
  localparam int unsigned SIZE_W        = 11;

  localparam logic [SIZE_W-1:0] MAP_SIZE_RST = 11'd1024;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_FIND  = 2'd3;

  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] start_pos;
    logic [POS_W-1:0] end_pos;
    logic             wanted_value;
  } bre_req_t;

  typedef struct packed {
    logic             status;
    logic             bit_read;
    logic             found;
    logic [POS_W-1:0] found_pos;
  } bre_rsp_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] hit_pos;
  } bre_scan_t;

endpackage

// ----- rtl/core/bre_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bre_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bre_word_unit.sv -----
// Word unit: range mask, set/clear merge and lowest-match search over one store word.
`timescale 1ns / 1ps

module bre_word_unit
  import bre_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned CMP_W     = 16
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [CMP_W-1:0]     base_i,
  input  logic [POS_W-1:0]     start_pos_i,
  input  logic [POS_W-1:0]     end_pos_i,
  input  logic                 wanted_i,
  input  logic                 set_i,
  output logic [WORD_BITS-1:0] new_word_o,
  output bre_scan_t            scan_o
);

  localparam int unsigned IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] match;
  logic [IDX_W-1:0]     idx;
  logic [CMP_W-1:0]     pos;
  logic [CMP_W-1:0]     sum;

  // A bit is in range when its absolute position lies in start..end.
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      pos     = base_i + CMP_W'(b);
      mask[b] = (pos >= CMP_W'(start_pos_i)) && (pos <= CMP_W'(end_pos_i));
    end
  end

  assign new_word_o = set_i ? (word_i | mask) : (word_i & ~mask);
  assign match      = (wanted_i ? word_i : ~word_i) & mask;

  // Priority encoder: walking down leaves the lowest matching index.
  always_comb begin
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (match[b]) begin
        idx = IDX_W'(b);
      end
    end
  end

  assign sum            = base_i + CMP_W'(idx);
  assign scan_o.hit     = |match;
  assign scan_o.hit_pos = sum[POS_W-1:0];

endmodule

// ----- rtl/core/bitmap_range_engine.sv -----
// Top level of the bitmap range engine: request sequencer, bit store and result register.
`timescale 1ns / 1ps

// Channel   Direction  Ports                     Transfer
// request   in         start, busy, req_i        at a rising edge with start high, busy low
// result    out        done_o, rsp_o             the one cycle in which done_o is high
// config    in         cfg_we_i, cfg_wdata_i     at a rising edge with cfg_we_i high
//
// A request walks the store one word per cycle, starting at word 0 and stopping at the
// word that holds the last position of the range (the read position for a read), or
// earlier when a find meets its first match; a rejected request walks no words.
// The store has a single read port and one shared word unit. Reset clears the word
// valid bits at once, so the store reads as all zeros with no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.

module bitmap_range_engine
  import bre_pkg::*;
#(
  parameter int unsigned MAX_BITS  = MAX_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  bre_req_t          req_i,
  output logic              done_o,
  output bre_rsp_t          rsp_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i
);

  // Store geometry and the width used for the position comparisons in the word walk and the size checks.
  localparam int unsigned WORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned SPAN_W = $clog2(WORDS * WORD_BITS + WORD_BITS + 1);
  localparam int unsigned CMP_W  = (SPAN_W > SIZE_W) ? SPAN_W : SIZE_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [SIZE_W-1:0]   map_size_q;
  logic [WORDS-1:0]    valid_q, valid_d;
  logic [ADDR_W-1:0]   word_q, word_d;
  logic [CMP_W-1:0]    base_q, base_d;
  logic [1:0]          op_q, op_d;
  logic [POS_W-1:0]    start_q, start_d;
  logic [POS_W-1:0]    end_q, end_d;
  logic                want_q, want_d;
  bre_rsp_t            rsp_q, rsp_d;
  logic                done_q, done_d;

  logic [CMP_W-1:0]     size_ext;
  logic [CMP_W-1:0]     eff_size;
  logic                 accept;
  logic                 bad_req;
  logic                 last_word;
  logic                 is_write;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  bre_scan_t            scan;

  // A size above the store capacity behaves as the capacity.
  assign size_ext = CMP_W'(map_size_q);
  assign eff_size = (size_ext > CMP_W'(MAX_BITS)) ? CMP_W'(MAX_BITS) : size_ext;

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  // Range checks are made once, when the request is taken.
  always_comb begin
    if (req_i.operation == OP_READ) begin
      bad_req = CMP_W'(req_i.start_pos) >= eff_size;
    end else begin
      bad_req = (CMP_W'(req_i.end_pos) >= eff_size) || (req_i.start_pos > req_i.end_pos);
    end
  end

  assign is_write  = (op_q == OP_SET) || (op_q == OP_CLEAR);
  assign last_word = (base_q + CMP_W'(WORD_BITS)) > CMP_W'(end_q);

  // A word never written since reset reads as zero.
  assign cur_word = valid_q[word_q] ? ram_rdata : '0;

  bre_word_unit #(
    .WORD_BITS (WORD_BITS),
    .CMP_W     (CMP_W)
  ) u_word_unit (
    .word_i      (cur_word),
    .base_i      (base_q),
    .start_pos_i (start_q),
    .end_pos_i   (end_q),
    .wanted_i    (want_q),
    .set_i       (op_q == OP_SET),
    .new_word_o  (new_word),
    .scan_o      (scan)
  );

  // The read for the next word is issued while the current one is merged and, for a set or
  // clear, written back, so the reads and the write-backs overlap.
  assign ram_we    = (state_q == ST_SCAN) && is_write;
  assign ram_raddr = (state_q == ST_SCAN) ? (word_q + ADDR_W'(1)) : '0;

  bre_ram #(
    .WIDTH  (WORD_BITS),
    .DEPTH  (WORDS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (word_q),
    .wdata_i (new_word),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    word_d  = word_q;
    base_d  = base_q;
    op_d    = op_q;
    start_d = start_q;
    end_d   = end_q;
    want_d  = want_q;
    rsp_d   = rsp_q;
    done_d  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // A read is a one-position range looking for a set bit.
          op_d    = req_i.operation;
          start_d = req_i.start_pos;
          end_d   = (req_i.operation == OP_READ) ? req_i.start_pos : req_i.end_pos;
          want_d  = (req_i.operation == OP_READ) ? 1'b1 : req_i.wanted_value;
          word_d  = '0;
          base_d  = '0;
          rsp_d   = '0;
          if (bad_req) begin
            rsp_d.status = 1'b1;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (is_write) begin
          valid_d[word_q] = 1'b1;
        end
        if (op_q == OP_READ) begin
          rsp_d.bit_read = rsp_q.bit_read | scan.hit;
        end
        if ((op_q == OP_FIND) && scan.hit) begin
          rsp_d.found     = 1'b1;
          rsp_d.found_pos = scan.hit_pos;
          state_d         = ST_DONE;
        end else if (last_word) begin
          state_d = ST_DONE;
        end else begin
          word_d = word_q + ADDR_W'(1);
          base_d = base_q + CMP_W'(WORD_BITS);
        end
      end
      ST_DONE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      map_size_q <= MAP_SIZE_RST;
      done_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        map_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    base_q  <= base_d;
    op_q    <= op_d;
    start_q <= start_d;
    end_q   <= end_d;
    want_q  <= want_d;
    rsp_q   <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ----- verif/bitmap_range_checker.sv -----
// Checker that predicts and compares every result of the bitmap range engine.
`timescale 1ns / 1ps

module bitmap_range_checker
  import bre_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  bre_req_t          req_i,
  input  logic              done_o,
  input  bre_rsp_t          rsp_o,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  output int                pending_o,
  output int                fail_o
);

  logic [MAX_BITS_DEF-1:0] bitmap   = '0;
  logic [SIZE_W-1:0]       map_size = MAP_SIZE_RST;
  bre_rsp_t                expected_rsp[$];
  int                      fail_cnt = 0;

  // Applies one request to the bit map copy and returns the result it must give.
  function automatic bre_rsp_t predict_bitmap_op(bre_req_t r);
    bre_rsp_t res;
    int       lim;
    int       s;
    int       e;
    res = '0;
    lim = (map_size > SIZE_W'(MAX_BITS_DEF)) ? MAX_BITS_DEF : int'(map_size);
    s   = r.start_pos;
    e   = r.end_pos;
    if (r.operation == OP_READ) begin
      if (s >= lim) res.status = 1'b1;
      else res.bit_read = bitmap[s];
    end else if (e >= lim || s > e) begin
      res.status = 1'b1;
    end else if (r.operation == OP_SET || r.operation == OP_CLEAR) begin
      for (int p = s; p <= e; p++) bitmap[p] = (r.operation == OP_SET);
    end else begin
      for (int p = s; p <= e; p++) begin
        if (bitmap[p] == r.wanted_value) begin
          res.found     = 1'b1;
          res.found_pos = POS_W'(p);
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : watch
    bre_rsp_t want;
    if (rst_ni) begin
      // The result of an earlier request is compared before a new request is predicted.
      if (done_o) begin
        if (expected_rsp.size() == 0) begin
          fail_cnt++;
          $display("%0t: result with no request outstanding, expected none, actual %h",
                   $time, rsp_o);
        end else begin
          want = expected_rsp.pop_front();
          compare_field("status", want.status, rsp_o.status);
          compare_field("bit_read", want.bit_read, rsp_o.bit_read);
          compare_field("found", want.found, rsp_o.found);
          compare_field("found_pos", want.found_pos, rsp_o.found_pos);
        end
      end
      if (cfg_we_i) map_size = cfg_wdata_i;
      if (start && !busy) expected_rsp.push_back(predict_bitmap_op(req_i));
    end
    pending_o <= expected_rsp.size();
    fail_o    <= fail_cnt;
  end

endmodule

// ----- verif/tb.sv -----
// Testbench top for the bitmap range engine: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import bre_pkg::*;

  // The slowest request walks all 32 words of the store; the limit leaves wide margin
  // for about nine hundred requests with gaps.
  localparam int CYCLE_LIMIT = 400000;
  // This quiet time after the last result outlasts the longest request, so it is
  // enough to catch a stray extra result.
  localparam int DRAIN_CYCLES = 40;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start       = 1'b0;
  logic              busy;
  bre_req_t          req_i       = '0;
  logic              done_o;
  bre_rsp_t          rsp_o;
  logic              cfg_we_i    = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;

  int pending;
  int fail_cnt;
  int cycle_cnt = 0;
  int op_cnt[4] = '{0, 0, 0, 0};
  int size_cnt  = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  bitmap_range_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  bitmap_range_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .pending_o  (pending),
    .fail_o     (fail_cnt)
  );

  // A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_cnt, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bre_req_t make_req(logic [1:0] op, int s, int e, logic want);
    bre_req_t r;
    r.operation    = op;
    r.start_pos    = POS_W'(s);
    r.end_pos      = POS_W'(e);
    r.wanted_value = want;
    return r;
  endfunction

  // Builds one random request for a map of lim bits in use. Most requests are
  // well formed and short so that they finish fast and keep the map mixed; the rest
  // are long ranges, reversed ranges, ranges past the size, or raw random fields.
  function automatic bre_req_t random_req(int lim);
    int roll;
    int s;
    int e;
    roll = $urandom_range(0, 99);
    s    = $urandom_range(0, 1023);
    e    = $urandom_range(0, 1023);
    if (lim > 0 && roll >= 10) begin
      if (roll < 15) begin
        // Start after end.
        e = $urandom_range(0, lim - 1);
        s = (e == 1023) ? 1023 : $urandom_range(e + 1, 1023);
        if (s == e) e = e - 1;
      end else if (roll < 20 && lim < 1024) begin
        // End at or past the size in use.
        e = $urandom_range(lim, 1023);
        s = $urandom_range(0, e);
      end else begin
        s = $urandom_range(0, lim - 1);
        if ($urandom_range(0, 99) < 80) e = s + $urandom_range(0, 40);
        else e = s + $urandom_range(0, lim - 1 - s);
        if (e > lim - 1) e = lim - 1;
      end
    end
    return make_req(2'($urandom_range(0, 3)), s, e, 1'($urandom));
  endfunction

  // Holds one request on the port until the transfer happens. The caller is at a
  // rising edge, and start is left high so a back-to-back request keeps it high.
  task automatic issue(bre_req_t r);
    req_i <= r;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    op_cnt[r.operation]++;
  endtask

  // Lowers start and waits until every outstanding result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  // The size register is only written while the engine is idle.
  task automatic write_size(int value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= SIZE_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_cnt++;
  endtask

  task automatic random_phase(int size_val, int count, bit idle_on);
    int lim;
    write_size(size_val);
    lim = (size_val > 1024) ? 1024 : size_val;
    for (int i = 0; i < count; i++) begin
      issue(random_req(lim));
      // Idle bursts land on any cycle of a request, since busy is not consulted here.
      if (idle_on && $urandom_range(0, 99) < 20) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. The map starts cleared and the size is the full 1024 bits.
    issue(make_req(OP_READ, 0, 0, 1'b0));
    issue(make_req(OP_FIND, 0, 1023, 1'b1));     // nothing set yet: not found
    issue(make_req(OP_FIND, 0, 1023, 1'b0));     // first zero is bit 0
    issue(make_req(OP_SET, 0, 1023, 1'b0));      // set every bit
    issue(make_req(OP_READ, 1023, 0, 1'b1));
    issue(make_req(OP_FIND, 0, 1023, 1'b0));     // no zero left
    issue(make_req(OP_CLEAR, 5, 5, 1'b0));
    issue(make_req(OP_FIND, 0, 1023, 1'b0));
    issue(make_req(OP_FIND, 1023, 1023, 1'b1));
    issue(make_req(OP_SET, 10, 9, 1'b1));        // start after end is rejected
    issue(make_req(OP_CLEAR, 0, 1023, 1'b1));    // clear every bit
    issue(make_req(OP_SET, 31, 32, 1'b0));       // range across a word boundary
    issue(make_req(OP_FIND, 0, 1023, 1'b1));

    // With a size of zero every request is rejected.
    write_size(0);
    issue(make_req(OP_READ, 0, 0, 1'b0));
    issue(make_req(OP_FIND, 0, 0, 1'b1));

    // A size beyond capacity behaves as the full map.
    write_size(2047);
    issue(make_req(OP_READ, 1023, 1023, 1'b0));
    issue(make_req(OP_SET, 1000, 1023, 1'b1));

    // Shrinking the size hides the high bits but keeps their values.
    write_size(16);
    issue(make_req(OP_SET, 0, 15, 1'b0));
    issue(make_req(OP_READ, 16, 0, 1'b0));
    issue(make_req(OP_CLEAR, 0, 16, 1'b0));      // end at the size is rejected
    issue(make_req(OP_FIND, 0, 15, 1'b1));

    // Growing it again brings the earlier bits back into use.
    write_size(1024);
    issue(make_req(OP_READ, 1010, 0, 1'b0));
    issue(make_req(OP_FIND, 16, 1023, 1'b1));

    // Random part over a spread of sizes, the extremes among them.
    random_phase(1024, 200, 1'b1);
    random_phase(37, 100, 1'b1);
    random_phase(1, 50, 1'b1);
    random_phase(2047, 100, 1'b1);
    random_phase(0, 25, 1'b1);
    random_phase($urandom_range(2, 1023), 75, 1'b1);
    // The sender holds off here until nothing is outstanding, mid-setting.
    wait_drained();
    random_phase(300, 75, 1'b1);
    random_phase(1024, 225, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d set, %0d clear, %0d read and %0d find requests over %0d sizes.",
             op_cnt[OP_SET], op_cnt[OP_CLEAR], op_cnt[OP_READ], op_cnt[OP_FIND], size_cnt);
    $display("Sizes ran from zero to past capacity, with rejected ranges and empty finds.");
    if (fail_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- bitmap_range_engine.f -----
rtl/core/bre_pkg.sv
rtl/core/bre_ram.sv
rtl/core/bre_word_unit.sv
rtl/core/bitmap_range_engine.sv
verif/bitmap_range_checker.sv
verif/tb.sv
